### rtl/rhmw_pkg.sv
package rhmw_pkg;

	// Position range that the 4-bit coordinates can reach
	localparam int POS_LIMIT = 16;

	// Default storage size
	localparam int MAX_ROWS_DEF = 16;
	localparam int MAX_COLS_DEF = 16;

	// Reset size of the active grid
	localparam logic [4:0] ACTIVE_RESET = 5'd12;

	// Input command codes
	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_START = 2'd1;
	localparam logic [1:0] CMD_STEP  = 2'd2;

	// Walk status codes
	localparam logic [1:0] STAT_WALK    = 2'd0;
	localparam logic [1:0] STAT_EXIT    = 2'd1;
	localparam logic [1:0] STAT_NO_EXIT = 2'd2;
	localparam logic [1:0] STAT_IDLE    = 2'd3;

	// Heading codes
	localparam logic [1:0] HD_RIGHT = 2'd0;
	localparam logic [1:0] HD_DOWN  = 2'd1;
	localparam logic [1:0] HD_LEFT  = 2'd2;
	localparam logic [1:0] HD_UP    = 2'd3;

	// Configuration register indexes
	localparam logic REG_ACTIVE_ROWS = 1'b0;
	localparam logic REG_ACTIVE_COLS = 1'b1;

	typedef struct packed {
		logic [1:0] command;
		logic [3:0] row;
		logic [3:0] col;
		logic       open;
	} in_word_t;

	typedef struct packed {
		logic [3:0] pos_row;
		logic [3:0] pos_col;
		logic [1:0] heading;
		logic [1:0] status;
	} out_word_t;

	// Which map row the datapath reads
	typedef enum logic [1:0] {
		RD_UP,
		RD_MID,
		RD_DN,
		RD_ITEM
	} rd_sel_t;

	typedef struct packed {
		logic    load_item;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_up;
		logic    cap_mid;
		logic    cap_dn;
		logic    wr_cell;
		logic    do_start;
		logic    do_step;
		logic    load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] command;
		logic       walking;
		logic       wr_in_range;
		logic       out_free;
	} dp_stat_t;

endpackage

### rtl/right_hand_maze_walker.sv
// Right-hand wall follower on a grid of open and wall cells.
// Input channel (in_valid/in_ready/in_word) takes one word per command:
// write one cell, start a walk at row/col heading right, or take one step.
// Every input word gives exactly one result word on the output channel
// (out_valid/out_ready/out_word): walker position, heading and walk status.
// Configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the active
// row and column counts; cfg_ready is always high, write only while idle.
// A start or an ignored command goes straight to the result, a cell write does
// a map row read-modify-write, and a step does three map row reads through the
// single read port, then the move. One word is in work at a time: a new word
// is accepted only after the last result is loaded into the output register.
// The output register parts the two sides: the next word is accepted while a
// result waits; if the receiver stalls, the following result holds inside
// and input stalls until the output register frees.
// Reset clears the map to all wall (per-row valid bits, no clearing pass),
// the walker to row 0, column 0, heading right, status idle, grid 12 x 12.
module right_hand_maze_walker #(
	parameter int MAX_ROWS = rhmw_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = rhmw_pkg::MAX_COLS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rhmw_pkg::in_word_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output rhmw_pkg::out_word_t out_word,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [4:0]          cfg_data
);

	rhmw_pkg::ctrl_cmd_t cmd;
	rhmw_pkg::dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	rhmw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rhmw_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_word   (in_word),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_word  (out_word),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

### rtl/rhmw_ctrl.sv
module rhmw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rhmw_pkg::dp_stat_t  stat,
	output rhmw_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_RD1,
		S_RD2,
		S_RD3,
		S_STEP,
		S_WR,
		S_RESULT
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign in_ready = (state_q == S_IDLE);

	// Sequence the map reads and updates for one word
	always_comb begin
		cmd = '0;
		cmd.rd_sel = rhmw_pkg::RD_MID;
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nx = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.command)
					rhmw_pkg::CMD_WRITE: begin
						if (stat.wr_in_range) begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = rhmw_pkg::RD_ITEM;
							state_nx = S_WR;
						end else begin
							state_nx = S_RESULT;
						end
					end
					rhmw_pkg::CMD_START: begin
						cmd.do_start = 1'b1;
						state_nx = S_RESULT;
					end
					rhmw_pkg::CMD_STEP: begin
						if (stat.walking) begin
							cmd.rd_en = 1'b1;
							cmd.rd_sel = rhmw_pkg::RD_UP;
							state_nx = S_RD1;
						end else begin
							state_nx = S_RESULT;
						end
					end
					default: begin
						state_nx = S_RESULT;
					end
				endcase
			end
			S_RD1: begin
				cmd.cap_up = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_sel = rhmw_pkg::RD_MID;
				state_nx = S_RD2;
			end
			S_RD2: begin
				cmd.cap_mid = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_sel = rhmw_pkg::RD_DN;
				state_nx = S_RD3;
			end
			S_RD3: begin
				cmd.cap_dn = 1'b1;
				state_nx = S_STEP;
			end
			S_STEP: begin
				cmd.do_step = 1'b1;
				state_nx = S_RESULT;
			end
			S_WR: begin
				cmd.wr_cell = 1'b1;
				state_nx = S_RESULT;
			end
			S_RESULT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nx = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_cell, cmd.do_start, cmd.do_step, cmd.load_out}))
		else $error("more than one state update in a cycle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> stat.out_free)
		else $error("result loaded over a waiting word");

	a_step_walking: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_step |-> stat.walking && $past(cmd.cap_dn))
		else $error("step taken without a full neighbor read");

endmodule

### rtl/rhmw_dp.sv
module rhmw_dp #(
	parameter int MAX_ROWS = rhmw_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = rhmw_pkg::MAX_COLS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rhmw_pkg::in_word_t   in_word,
	input  rhmw_pkg::ctrl_cmd_t  cmd,
	output rhmw_pkg::dp_stat_t   stat,
	input  logic                 cfg_valid,
	input  logic                 cfg_index,
	input  logic [4:0]           cfg_data,
	output rhmw_pkg::out_word_t  out_word,
	output logic                 out_valid,
	input  logic                 out_ready
);

	// Rows and columns that a 4-bit position can reach
	localparam int NR = (MAX_ROWS < rhmw_pkg::POS_LIMIT) ? MAX_ROWS : rhmw_pkg::POS_LIMIT;
	localparam int NC = (MAX_COLS < rhmw_pkg::POS_LIMIT) ? MAX_COLS : rhmw_pkg::POS_LIMIT;
	localparam int AW = $clog2(NR);

	function automatic logic row_bit(input logic [NC-1:0] v, input logic [4:0] idx);
		logic [NC-1:0] s;
		s = v >> idx;
		return s[0];
	endfunction

	rhmw_pkg::in_word_t  item_q;
	rhmw_pkg::out_word_t out_q;
	logic                out_valid_q;
	logic [4:0]          rows_q;
	logic [4:0]          cols_q;
	logic [3:0]          cur_row_q;
	logic [3:0]          cur_col_q;
	logic [1:0]          heading_q;
	logic [3:0]          start_row_q;
	logic [3:0]          start_col_q;
	logic [1:0]          status_q;

	logic [NC-1:0] map_mem [NR];
	logic [NR-1:0] row_vld_q;
	logic [NC-1:0] rd_data_q;
	logic          rd_vld_q;
	logic [NC-1:0] up_q;
	logic [NC-1:0] mid_q;
	logic [NC-1:0] dn_q;

	logic [3:0]    rd_row;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [NC-1:0] rd_word;
	logic [NC-1:0] wr_mask;
	logic [NC-1:0] wr_word;

	logic [4:0] nr;
	logic [4:0] nc;
	logic [4:0] r5;
	logic [4:0] c5;
	logic [3:0] open_dir;
	logic [1:0] hd_right;
	logic [1:0] hd_new;
	logic [3:0] new_row;
	logic [3:0] new_col;
	logic       at_border;

	// Status to the controller
	assign stat.command     = item_q.command;
	assign stat.walking     = (status_q == rhmw_pkg::STAT_WALK);
	assign stat.wr_in_range = ({1'b0, item_q.row} < 5'(NR)) && ({1'b0, item_q.col} < 5'(NC));
	assign stat.out_free    = !out_valid_q || out_ready;

	assign out_word  = out_q;
	assign out_valid = out_valid_q;

	// Pick the map row to read
	always_comb begin
		unique case (cmd.rd_sel)
			rhmw_pkg::RD_UP:   rd_row = cur_row_q - 4'd1;
			rhmw_pkg::RD_MID:  rd_row = cur_row_q;
			rhmw_pkg::RD_DN:   rd_row = cur_row_q + 4'd1;
			rhmw_pkg::RD_ITEM: rd_row = item_q.row;
			default:           rd_row = cur_row_q;
		endcase
	end
	assign rd_addr = rd_row[AW-1:0];
	assign wr_addr = item_q.row[AW-1:0];

	// A row never written reads as all wall
	assign rd_word = rd_vld_q ? rd_data_q : '0;
	assign wr_mask = {{(NC-1){1'b0}}, 1'b1} << item_q.col;
	assign wr_word = item_q.open ? (rd_word | wr_mask) : (rd_word & ~wr_mask);

	// Map memory: one read and one write port
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= map_mem[rd_addr];
		end
		if (cmd.wr_cell) begin
			map_mem[wr_addr] <= wr_word;
		end
	end

	// Row valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.rd_en) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
			if (cmd.wr_cell) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	// Capture the item and the neighbor rows
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_q <= in_word;
		end
		if (cmd.cap_up) begin
			up_q <= rd_word;
		end
		if (cmd.cap_mid) begin
			mid_q <= rd_word;
		end
		if (cmd.cap_dn) begin
			dn_q <= rd_word;
		end
		if (cmd.load_out) begin
			out_q <= '{pos_row: cur_row_q, pos_col: cur_col_q,
				heading: heading_q, status: status_q};
		end
	end

	// Clamp the active grid to at least 2 x 2 and at most what is stored
	always_comb begin
		priority if (rows_q < 5'd2) begin
			nr = 5'd2;
		end else if (rows_q > 5'(NR)) begin
			nr = 5'(NR);
		end else begin
			nr = rows_q;
		end
		priority if (cols_q < 5'd2) begin
			nc = 5'd2;
		end else if (cols_q > 5'(NC)) begin
			nc = 5'(NC);
		end else begin
			nc = cols_q;
		end
	end

	assign r5 = {1'b0, cur_row_q};
	assign c5 = {1'b0, cur_col_q};

	// Open neighbors, cells outside the active grid are wall
	always_comb begin
		open_dir[rhmw_pkg::HD_RIGHT] = (r5 < nr) && ((c5 + 5'd1) < nc)
			&& row_bit(mid_q, c5 + 5'd1);
		open_dir[rhmw_pkg::HD_DOWN]  = ((r5 + 5'd1) < nr) && (c5 < nc)
			&& row_bit(dn_q, c5);
		open_dir[rhmw_pkg::HD_LEFT]  = (c5 != 5'd0) && (r5 < nr) && ((c5 - 5'd1) < nc)
			&& row_bit(mid_q, c5 - 5'd1);
		open_dir[rhmw_pkg::HD_UP]    = (r5 != 5'd0) && ((r5 - 5'd1) < nr) && (c5 < nc)
			&& row_bit(up_q, c5);
	end

	// Right-hand rule: right, forward, left, back
	assign hd_right = heading_q + 2'd1;
	always_comb begin
		priority if (open_dir[hd_right]) begin
			hd_new = hd_right;
		end else if (open_dir[heading_q]) begin
			hd_new = heading_q;
		end else if (open_dir[heading_q + 2'd3]) begin
			hd_new = heading_q + 2'd3;
		end else if (open_dir[heading_q + 2'd2]) begin
			hd_new = heading_q + 2'd2;
		end else begin
			hd_new = hd_right;
		end
	end

	// Advance one cell if the chosen cell is open
	always_comb begin
		new_row = cur_row_q;
		new_col = cur_col_q;
		if (open_dir[hd_new]) begin
			unique case (hd_new)
				rhmw_pkg::HD_RIGHT: new_col = cur_col_q + 4'd1;
				rhmw_pkg::HD_DOWN:  new_row = cur_row_q + 4'd1;
				rhmw_pkg::HD_LEFT:  new_col = cur_col_q - 4'd1;
				rhmw_pkg::HD_UP:    new_row = cur_row_q - 4'd1;
				default:            new_row = cur_row_q;
			endcase
		end
	end

	assign at_border = (new_row == 4'd0) || (new_col == 4'd0)
		|| ({1'b0, new_row} == (nr - 5'd1)) || ({1'b0, new_col} == (nc - 5'd1));

	// Walker state, configuration and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= rhmw_pkg::ACTIVE_RESET;
			cols_q      <= rhmw_pkg::ACTIVE_RESET;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			heading_q   <= rhmw_pkg::HD_RIGHT;
			start_row_q <= '0;
			start_col_q <= '0;
			status_q    <= rhmw_pkg::STAT_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					rhmw_pkg::REG_ACTIVE_ROWS: rows_q <= cfg_data;
					rhmw_pkg::REG_ACTIVE_COLS: cols_q <= cfg_data;
					default:                   rows_q <= rows_q;
				endcase
			end
			if (cmd.do_start) begin
				cur_row_q   <= item_q.row;
				cur_col_q   <= item_q.col;
				start_row_q <= item_q.row;
				start_col_q <= item_q.col;
				heading_q   <= rhmw_pkg::HD_RIGHT;
				status_q    <= rhmw_pkg::STAT_WALK;
			end
			if (cmd.do_step) begin
				cur_row_q <= new_row;
				cur_col_q <= new_col;
				heading_q <= hd_new;
				if (at_border) begin
					status_q <= ((new_row == start_row_q) && (new_col == start_col_q))
						? rhmw_pkg::STAT_NO_EXIT : rhmw_pkg::STAT_EXIT;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_start |=> status_q == rhmw_pkg::STAT_WALK && heading_q == rhmw_pkg::HD_RIGHT
			&& cur_row_q == start_row_q && cur_col_q == start_col_q)
		else $error("start did not set up the walk");

	a_row_written: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_cell |=> row_vld_q[$past(wr_addr)])
		else $error("written row not marked valid");

	a_step_ends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_step |=> status_q != rhmw_pkg::STAT_IDLE)
		else $error("step left the walker idle");

endmodule
